/* rtl/hxd_pkg.sv */
`timescale 1ns / 1ps

package hxd_pkg;

  // Default width of one cell temperature word, LSB 1/128 degree C.
  localparam int TEMP_WIDTH_DEF = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Register field widths.
  localparam int RECIP_W  = 18;
  localparam int UA_W     = 13;
  localparam int FLOWCP_W = 10;
  localparam int HIN_W    = 15;
  localparam int CIN_W    = 13;
  localparam int FMOD_W   = 10;

  // A flow modifier of 1.0 is 2^8; the exchange and cold flow terms are shifted up to that scale.
  localparam int FMOD_ONE_SHIFT = 8;

  // Rate scaling: floor(P * recip / 2^23), with P split at bit 32.
  localparam int SCALE_SHIFT = 23;
  localparam int LO_W        = 32;
  localparam int RATE_W      = 32;

  localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  // Pipeline depth: three stages form the powers, four scale them.
  localparam int NUM_STAGES = 7;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HOT_RECIP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLD_RECIP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UA         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_FLOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLD_FLOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_INLET  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLD_INLET = 3'd6;

  typedef struct packed {
    logic [RECIP_W-1:0]  hot_recip;
    logic [RECIP_W-1:0]  cold_recip;
    logic [UA_W-1:0]     ua;
    logic [FLOWCP_W-1:0] hot_flow_cp;
    logic [FLOWCP_W-1:0] cold_flow_cp;
    logic [HIN_W-1:0]    hot_inlet;
    logic [CIN_W-1:0]    cold_inlet;
  } hxd_cfg_t;

  localparam hxd_cfg_t CFG_RESET = '{
    hot_recip:    18'd8389,
    cold_recip:   18'd8389,
    ua:           13'd500,
    hot_flow_cp:  10'd100,
    cold_flow_cp: 10'd80,
    hot_inlet:    15'd11520,
    cold_inlet:   13'd2560
  };

  // Stage load enables of the power front end.
  typedef struct packed {
    logic diff;
    logic mult;
    logic sum;
  } hxd_front_en_t;

  // Stage load enables of one rate scaling lane.
  typedef struct packed {
    logic mag;
    logic part;
    logic comb;
    logic sat;
  } hxd_back_en_t;

  // Width of every temperature difference, inlet terms included.
  function automatic int diff_w(input int tw);
    return ((tw > HIN_W + 1) ? tw : HIN_W + 1) + 1;
  endfunction

  // Width of a net power in units of 2^-15 W.
  function automatic int power_w(input int tw);
    return diff_w(tw) + UA_W + FMOD_ONE_SHIFT + 2;
  endfunction

endpackage

/* rtl/hxd_cfg.sv */
`timescale 1ns / 1ps

module hxd_cfg import hxd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output hxd_cfg_t              cfg
);

  hxd_cfg_t cfg_r;
  hxd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HOT_RECIP:  cfg_nxt.hot_recip    = cfg_wdata[RECIP_W-1:0];
        REG_COLD_RECIP: cfg_nxt.cold_recip   = cfg_wdata[RECIP_W-1:0];
        REG_UA:         cfg_nxt.ua           = cfg_wdata[UA_W-1:0];
        REG_HOT_FLOW:   cfg_nxt.hot_flow_cp  = cfg_wdata[FLOWCP_W-1:0];
        REG_COLD_FLOW:  cfg_nxt.cold_flow_cp = cfg_wdata[FLOWCP_W-1:0];
        REG_HOT_INLET:  cfg_nxt.hot_inlet    = cfg_wdata[HIN_W-1:0];
        REG_COLD_INLET: cfg_nxt.cold_inlet   = cfg_wdata[CIN_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/hxd_front.sv */
`timescale 1ns / 1ps

module hxd_front import hxd_pkg::*; #(
  parameter int TEMP_WIDTH = TEMP_WIDTH_DEF,
  parameter int POWER_W    = power_w(TEMP_WIDTH_DEF)
) (
  input  logic                         clk,
  input  hxd_front_en_t                en,
  input  hxd_cfg_t                     cfg,
  input  logic signed [TEMP_WIDTH-1:0] hot_temp_first,
  input  logic signed [TEMP_WIDTH-1:0] hot_temp_second,
  input  logic signed [TEMP_WIDTH-1:0] cold_temp_first,
  input  logic signed [TEMP_WIDTH-1:0] cold_temp_second,
  input  logic [FMOD_W-1:0]            flow_modifier,
  output logic signed [POWER_W-1:0]    p_hot_first,
  output logic signed [POWER_W-1:0]    p_hot_second,
  output logic signed [POWER_W-1:0]    p_cold_first,
  output logic signed [POWER_W-1:0]    p_cold_second
);

  localparam int DW   = diff_w(TEMP_WIDTH);
  localparam int HF_W = FLOWCP_W + FMOD_W;

  // Stage 1: temperature differences and the modified hot flow.
  logic signed [DW-1:0] th1_x, th2_x, tc1_x, tc2_x, hin_x, cin_x;
  logic signed [DW-1:0] dh_in_nxt, dh_12_nxt, dc_in_nxt, dc_12_nxt, x12_nxt, x21_nxt;
  logic signed [DW-1:0] dh_in_r, dh_12_r, dc_in_r, dc_12_r, x12_r, x21_r;
  logic [HF_W-1:0]      hflow_nxt, hflow_r;

  assign th1_x = DW'(hot_temp_first);
  assign th2_x = DW'(hot_temp_second);
  assign tc1_x = DW'(cold_temp_first);
  assign tc2_x = DW'(cold_temp_second);
  assign hin_x = DW'(cfg.hot_inlet);
  assign cin_x = DW'(cfg.cold_inlet);

  assign dh_in_nxt = hin_x - th1_x;
  assign dh_12_nxt = th1_x - th2_x;
  assign dc_in_nxt = cin_x - tc1_x;
  assign dc_12_nxt = tc1_x - tc2_x;
  assign x12_nxt   = th1_x - tc2_x;
  assign x21_nxt   = th2_x - tc1_x;
  assign hflow_nxt = cfg.hot_flow_cp * flow_modifier;

  always_ff @(posedge clk) begin
    if (en.diff) begin
      dh_in_r <= dh_in_nxt;
      dh_12_r <= dh_12_nxt;
      dc_in_r <= dc_in_nxt;
      dc_12_r <= dc_12_nxt;
      x12_r   <= x12_nxt;
      x21_r   <= x21_nxt;
      hflow_r <= hflow_nxt;
    end
  end

  // Stage 2: one multiplier per term. Fixed scale factors of 256 come in stage 3.
  logic signed [HF_W:0]       hflow_s;
  logic signed [FLOWCP_W:0]   cflow_s;
  logic signed [UA_W:0]       ua_s;
  logic signed [POWER_W-1:0]  mh_in_nxt, mh_12_nxt, mc_in_nxt, mc_12_nxt, q12_nxt, q21_nxt;
  logic signed [POWER_W-1:0]  mh_in_r, mh_12_r, mc_in_r, mc_12_r, q12_r, q21_r;

  assign hflow_s = $signed({1'b0, hflow_r});
  assign cflow_s = $signed({1'b0, cfg.cold_flow_cp});
  assign ua_s    = $signed({1'b0, cfg.ua});

  assign mh_in_nxt = hflow_s * dh_in_r;
  assign mh_12_nxt = hflow_s * dh_12_r;
  assign mc_in_nxt = cflow_s * dc_in_r;
  assign mc_12_nxt = cflow_s * dc_12_r;
  assign q12_nxt   = ua_s * x12_r;
  assign q21_nxt   = ua_s * x21_r;

  always_ff @(posedge clk) begin
    if (en.mult) begin
      mh_in_r <= mh_in_nxt;
      mh_12_r <= mh_12_nxt;
      mc_in_r <= mc_in_nxt;
      mc_12_r <= mc_12_nxt;
      q12_r   <= q12_nxt;
      q21_r   <= q21_nxt;
    end
  end

  // Stage 3: net powers. Exchange heat leaves the hot side and enters the cold side.
  logic signed [POWER_W-1:0] ph1_nxt, ph2_nxt, pc1_nxt, pc2_nxt;
  logic signed [POWER_W-1:0] ph1_r, ph2_r, pc1_r, pc2_r;

  assign ph1_nxt = mh_in_r - (q12_r <<< FMOD_ONE_SHIFT);
  assign ph2_nxt = mh_12_r - (q21_r <<< FMOD_ONE_SHIFT);
  assign pc1_nxt = (mc_in_r <<< FMOD_ONE_SHIFT) + (q21_r <<< FMOD_ONE_SHIFT);
  assign pc2_nxt = (mc_12_r <<< FMOD_ONE_SHIFT) + (q12_r <<< FMOD_ONE_SHIFT);

  always_ff @(posedge clk) begin
    if (en.sum) begin
      ph1_r <= ph1_nxt;
      ph2_r <= ph2_nxt;
      pc1_r <= pc1_nxt;
      pc2_r <= pc2_nxt;
    end
  end

  assign p_hot_first   = ph1_r;
  assign p_hot_second  = ph2_r;
  assign p_cold_first  = pc1_r;
  assign p_cold_second = pc2_r;

endmodule

/* rtl/hxd_scale.sv */
`timescale 1ns / 1ps

module hxd_scale import hxd_pkg::*; #(
  parameter int POWER_W = power_w(TEMP_WIDTH_DEF)
) (
  input  logic                      clk,
  input  hxd_back_en_t              en,
  input  logic [RECIP_W-1:0]        recip,
  input  logic signed [POWER_W-1:0] power,
  output logic signed [RATE_W-1:0]  rate
);

  localparam int HI_W = POWER_W - LO_W;
  localparam int LP_W = LO_W + RECIP_W;
  localparam int HP_W = HI_W + RECIP_W;
  localparam int PAD  = LO_W - SCALE_SHIFT;
  localparam int QW   = HP_W + PAD + 1;

  localparam logic [QW-1:0] NEG_LIM = {{(QW-RATE_W){1'b0}}, 1'b1, {(RATE_W-1){1'b0}}};
  localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

  // Stage 1: sign and magnitude. The most negative power has a magnitude that still fits.
  logic               neg_mag_nxt, neg_mag_r;
  logic [POWER_W-1:0] mag_nxt, mag_r;

  assign neg_mag_nxt = power[POWER_W-1];
  assign mag_nxt     = neg_mag_nxt ? POWER_W'(-power) : POWER_W'(power);

  always_ff @(posedge clk) begin
    if (en.mag) begin
      neg_mag_r <= neg_mag_nxt;
      mag_r     <= mag_nxt;
    end
  end

  // Stage 2: two partial products, low 32 bits and the rest.
  logic            neg_part_r;
  logic [LP_W-1:0] lo_prod_nxt, lo_prod_r;
  logic [HP_W-1:0] hi_prod_nxt, hi_prod_r;

  assign lo_prod_nxt = mag_r[LO_W-1:0] * recip;
  assign hi_prod_nxt = mag_r[POWER_W-1:LO_W] * recip;

  always_ff @(posedge clk) begin
    if (en.part) begin
      neg_part_r <= neg_mag_r;
      lo_prod_r  <= lo_prod_nxt;
      hi_prod_r  <= hi_prod_nxt;
    end
  end

  // Stage 3: truncated quotient of the magnitude and a flag for discarded bits.
  logic          neg_comb_r;
  logic [QW-1:0] q_nxt, q_r;
  logic          rem_nxt, rem_r;

  assign q_nxt   = QW'({hi_prod_r, {PAD{1'b0}}}) + QW'(lo_prod_r[LP_W-1:SCALE_SHIFT]);
  assign rem_nxt = |lo_prod_r[SCALE_SHIFT-1:0];

  always_ff @(posedge clk) begin
    if (en.comb) begin
      neg_comb_r <= neg_part_r;
      q_r        <= q_nxt;
      rem_r      <= rem_nxt;
    end
  end

  // Stage 4: floor for negative values, then saturation. -(q + rem) equals ~q + !rem.
  logic                     ovf_neg;
  logic signed [RATE_W-1:0] rate_nxt, rate_r;

  assign ovf_neg = rem_r ? (q_r >= NEG_LIM) : (q_r > NEG_LIM);

  always_comb begin
    if (!neg_comb_r) begin
      rate_nxt = (q_r > POS_LIM) ? RATE_MAX : q_r[RATE_W-1:0];
    end else if (ovf_neg) begin
      rate_nxt = RATE_MIN;
    end else begin
      rate_nxt = ~q_r[RATE_W-1:0] + {{(RATE_W-1){1'b0}}, !rem_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en.sat) begin
      rate_r <= rate_nxt;
    end
  end

  assign rate = rate_r;

endmodule

/* rtl/counterflow_heat_exchanger_derivative.sv */
`timescale 1ns / 1ps
// Derivative evaluator for a counter-flow heat exchanger lumped into two cells per side.
// The input channel carries one word of four cell temperatures (signed, 1/128 degree C)
// and a hot flow modifier (256 means 1.0). The output channel returns one word of four
// temperature rates in 1/65536 K/s, each saturated to the signed 32-bit range.
// Both channels use valid and stall; a word moves on a clock edge with valid high and
// stall low. The configuration port writes one register per cycle with cfg_we; the
// user must write it only while no word is in flight; the block does not enforce this.
// The pipeline has seven register stages: differences, products, net powers, magnitude,
// partial products of the reciprocal scaling, quotient, and the saturated output
// register. Throughput is one word per cycle while the receiver does not stall,
// with a multiplier of its own for every product term.
// Reset clears the valid bit of every stage and loads the register defaults.
// When the receiver stalls, the output word holds and each stage fills up in turn;
// in_stall rises only once every stage holds a word, so no cycle is wasted.
module counterflow_heat_exchanger_derivative import hxd_pkg::*; #(
  parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [TEMP_WIDTH-1:0] in_hot_temp_first,
  input  logic signed [TEMP_WIDTH-1:0] in_hot_temp_second,
  input  logic signed [TEMP_WIDTH-1:0] in_cold_temp_first,
  input  logic signed [TEMP_WIDTH-1:0] in_cold_temp_second,
  input  logic [FMOD_W-1:0]            in_flow_modifier,
  // Output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [RATE_W-1:0]     out_hot_first_rate,
  output logic signed [RATE_W-1:0]     out_hot_second_rate,
  output logic signed [RATE_W-1:0]     out_cold_first_rate,
  output logic signed [RATE_W-1:0]     out_cold_second_rate
);

  localparam int POWER_W = power_w(TEMP_WIDTH);

  // Stage control. A stage loads when it is empty or when the next stage loads, so a
  // bubble anywhere is squeezed out even while the receiver stalls.
  logic [NUM_STAGES:1] vld_r, vld_nxt;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !vld_r[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld_r[NUM_STAGES];

  hxd_front_en_t front_en;
  hxd_back_en_t  back_en;

  assign front_en = '{diff: en[1], mult: en[2], sum: en[3]};
  assign back_en  = '{mag: en[4], part: en[5], comb: en[6], sat: en[7]};

  // Configuration registers.
  hxd_cfg_t cfg;

  hxd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Net powers of the four cells.
  logic signed [POWER_W-1:0] p_hot_first, p_hot_second, p_cold_first, p_cold_second;

  hxd_front #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .POWER_W    (POWER_W)
  ) u_front (
    .clk              (clk),
    .en               (front_en),
    .cfg              (cfg),
    .hot_temp_first   (in_hot_temp_first),
    .hot_temp_second  (in_hot_temp_second),
    .cold_temp_first  (in_cold_temp_first),
    .cold_temp_second (in_cold_temp_second),
    .flow_modifier    (in_flow_modifier),
    .p_hot_first      (p_hot_first),
    .p_hot_second     (p_hot_second),
    .p_cold_first     (p_cold_first),
    .p_cold_second    (p_cold_second)
  );

  // One scaling lane per cell; each side uses its own reciprocal capacitance.
  hxd_scale #(.POWER_W(POWER_W)) u_scale_h1 (
    .clk   (clk),
    .en    (back_en),
    .recip (cfg.hot_recip),
    .power (p_hot_first),
    .rate  (out_hot_first_rate)
  );

  hxd_scale #(.POWER_W(POWER_W)) u_scale_h2 (
    .clk   (clk),
    .en    (back_en),
    .recip (cfg.hot_recip),
    .power (p_hot_second),
    .rate  (out_hot_second_rate)
  );

  hxd_scale #(.POWER_W(POWER_W)) u_scale_c1 (
    .clk   (clk),
    .en    (back_en),
    .recip (cfg.cold_recip),
    .power (p_cold_first),
    .rate  (out_cold_first_rate)
  );

  hxd_scale #(.POWER_W(POWER_W)) u_scale_c2 (
    .clk   (clk),
    .en    (back_en),
    .recip (cfg.cold_recip),
    .power (p_cold_second),
    .rate  (out_cold_second_rate)
  );

endmodule

/* rtl/hxd_checker.sv */
`timescale 1ns / 1ps

module hxd_checker import hxd_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [RATE_W-1:0] out_hot_first_rate,
  input logic signed [RATE_W-1:0] out_hot_second_rate,
  input logic signed [RATE_W-1:0] out_cold_first_rate,
  input logic signed [RATE_W-1:0] out_cold_second_rate
);

  // Reset empties every stage, seen here as a low output valid.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // An empty pipeline takes a word at once.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // Input backpressure only comes from a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output is free");

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hot_first_rate)
      && $stable(out_hot_second_rate) && $stable(out_cold_first_rate)
      && $stable(out_cold_second_rate))
    else $error("stalled output word changed");

endmodule

bind counterflow_heat_exchanger_derivative hxd_checker u_hxd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_hot_first_rate   (out_hot_first_rate),
  .out_hot_second_rate  (out_hot_second_rate),
  .out_cold_first_rate  (out_cold_first_rate),
  .out_cold_second_rate (out_cold_second_rate)
);
